/* hw/rtl/cpdt_pkg.sv */
`timescale 1ns / 1ps
// cpdt_pkg: shared types and constants of the constant pool dedup table
// no dependencies

package cpdt_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned STAT_W = 2;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_FOUND = 2'd0;
  localparam status_t ST_ADDED = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   index;
  } res_t;

endpackage

/* hw/rtl/cpdt_mem.sv */
`timescale 1ns / 1ps
// cpdt_mem: single write, single read entry store with registered read data
// no dependencies

module cpdt_mem #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned AW          = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          wr_addr,
  input  logic [VALUE_WIDTH-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [VALUE_WIDTH-1:0] rd_data
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/cpdt_seq.sv */
`timescale 1ns / 1ps
// cpdt_seq: search sequencer with the shared compare unit and fill count
// depends on cpdt_pkg

module cpdt_seq #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned AW          = $clog2(DEPTH),
  parameter int unsigned CW          = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   mem_rd_en,
  output logic [AW-1:0]          mem_rd_addr,
  input  logic [VALUE_WIDTH-1:0] mem_rd_data,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_wr_addr,
  output logic [VALUE_WIDTH-1:0] mem_wr_data,
  output logic                   res_valid,
  input  logic                   res_ready,
  output cpdt_pkg::res_t         res
);

  import cpdt_pkg::*;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CW-1:0]          used_r;
  logic [CW-1:0]          addr_r;
  logic                   pend_r;
  logic [CW-1:0]          pend_addr_r;
  logic [CW-1:0]          pos_r;
  status_t                status_r;

  logic                   issue;
  logic                   hit;
  logic                   scan_done;
  logic                   has_room;
  logic [CW+IDX_W-1:0]    pos_ext;

  assign issue     = (state_r == S_SCAN) && (addr_r < used_r);
  assign hit       = (state_r == S_SCAN) && pend_r && (mem_rd_data == val_r);
  assign scan_done = (state_r == S_SCAN) && !issue && !pend_r;
  assign has_room  = used_r < CW'(DEPTH);
  assign pos_ext   = {{IDX_W{1'b0}}, pos_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_value == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_DONE;
        end else if (scan_done) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = (state_r == S_IDLE);
    mem_rd_en    = issue;
    mem_rd_addr  = addr_r[AW-1:0];
    mem_we       = (state_r == S_RESOLVE) && has_room;
    mem_wr_addr  = used_r[AW-1:0];
    mem_wr_data  = val_r;
    res_valid    = (state_r == S_DONE);
    res.index    = pos_ext[IDX_W-1:0];
    res.status   = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= CW'(1);
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          pend_r <= 1'b0;
        end
        S_SCAN: begin
          pend_r <= issue && !hit;
        end
        S_RESOLVE: begin
          pend_r <= 1'b0;
          if (has_room) begin
            used_r <= used_r + CW'(1);
          end
        end
        S_DONE: begin
          pend_r <= 1'b0;
        end
        default: pend_r <= 1'b0;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_r    <= in_value;
          addr_r   <= CW'(1);
          pos_r    <= '0;
          status_r <= ST_FOUND;
        end
      end
      S_SCAN: begin
        pend_addr_r <= addr_r;
        if (issue) begin
          addr_r <= addr_r + CW'(1);
        end
        if (hit) begin
          pos_r    <= pend_addr_r;
          status_r <= ST_FOUND;
        end
      end
      S_RESOLVE: begin
        if (has_room) begin
          pos_r    <= used_r;
          status_r <= ST_ADDED;
        end else begin
          pos_r    <= '0;
          status_r <= ST_FULL;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/constant_pool_dedup_table_unit.sv */
`timescale 1ns / 1ps
// constant_pool_dedup_table_unit: top level, stream ports and output register
// depends on cpdt_pkg, cpdt_seq, cpdt_mem
// search: a zero value resolves at once to index 0, a hit at index k ends the scan,
// a miss scans every used entry, then adds the value or reports the table full
// throughput: one value at a time, taken only while idle; one entry read a cycle
// reset: synchronous active low; table returns to entry 0 only, no clearing pass

module constant_pool_dedup_table_unit #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] in_tdata,   // value
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [15:0]                            out_tdata   // index, status
);

  import cpdt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  logic [VALUE_WIDTH-1:0] mem_rd_data;
  logic                   mem_we;
  logic [AW-1:0]          mem_wr_addr;
  logic [VALUE_WIDTH-1:0] mem_wr_data;
  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;
  logic                   out_vld_r;
  res_t                   out_res_r;

  assign res_ready = !out_vld_r || out_tready;

  cpdt_seq #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_value    (in_tdata[VALUE_WIDTH-1:0]),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_we      (mem_we),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  cpdt_mem #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_ready) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(16 - IDX_W - STAT_W){1'b0}}, out_res_r.status, out_res_r.index};

endmodule
